/* hdl/ccmp_pkg.sv */
// Package: constants, types and AES helper functions for the CCMP engine.
package ccmp_pkg;

   // Storage
   localparam int QUEUE_DEPTH = 4;
   localparam int NUM_ROUND_KEYS = 11;
   localparam int LAST_ROUND = 10;

   // Block formatting constants
   localparam logic [7:0] ADATA_FLAG = 8'h40;
   localparam logic [7:0] B0_FLAGS = 8'h19;
   localparam logic [7:0] CTR_FLAGS = 8'h01;

   // Configuration register indexes
   localparam logic [2:0] CSR_KEY_HIGH = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW = 3'd1;
   localparam logic [2:0] CSR_NONCE_UPPER = 3'd2;
   localparam logic [2:0] CSR_NONCE_LOWER = 3'd3;
   localparam logic [2:0] CSR_AAD_LENGTH = 3'd4;
   localparam logic [2:0] CSR_MESSAGE_LENGTH = 3'd5;
   localparam logic [2:0] CSR_DIRECTION = 3'd6;

   // Request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_MSG = 2'd0;
   localparam logic [1:0] KIND_MIC = 2'd1;
   localparam logic [1:0] KIND_VERIFY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY,
      ST_LOAD,
      ST_RUN,
      ST_SECTION,
      ST_MSG,
      ST_TAG,
      ST_VERIFY
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_AAD,
      PH_MSG,
      PH_MIC
   } phase_type;

   typedef enum logic [1:0] {
      DST_B0,
      DST_MASK,
      DST_KS,
      DST_ABSORB
   } dest_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // Byte k of a block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input logic [127:0] v, input logic [3:0] k);
      get_byte = v[127 - 8*k -: 8];
   endfunction

   function automatic logic [127:0] set_byte(input logic [127:0] v, input logic [3:0] k,
                                             input logic [7:0] b);
      logic [127:0] r;
      r = v;
      r[127 - 8*k -: 8] = b;
      set_byte = r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // One AES round without the round key; the final round skips MixColumns
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4*c] = SBOX[get_byte(s, 4'((i + 4*((c + i) % 4))))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c];
         a1 = t[4*c+1];
         a2 = t[4*c+2];
         a3 = t[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (!final_rnd) begin
            t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int k = 0; k < 16; k++) begin
         r[127 - 8*k -: 8] = t[k];
      end
      aes_round = r;
   endfunction

   // Next round key from the previous one
   function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] tw, w0, w1, w2, w3;
      tw = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      w0 = k[127:96] ^ tw;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      key_next = {w0, w1, w2, w3};
   endfunction

endpackage

/* hdl/ccmp_if.sv */
// Interfaces: request and response channels with valid/ready handshake.
interface ccmp_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   modport source (output valid, output func, output data_byte, input ready);
   modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface ccmp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       auth_ok;
   logic       last;
   modport source (output valid, output out_byte, output kind, output auth_ok, output last,
                   input ready);
   modport sink (input valid, input out_byte, input kind, input auth_ok, input last,
                 output ready);
endinterface

/* hdl/ccmp_front.sv */
// Front end: accepts requests into a short queue ahead of the engine.
module ccmp_front #(
   parameter int QUEUE_DEPTH = ccmp_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   ccmp_req_if.sink   req_if,
   ccmp_req_if.source q_if
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic       func_ff [QUEUE_DEPTH];
   logic [7:0] data_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push, pop;

   assign req_if.ready = (count_ff != CW'(QUEUE_DEPTH));
   assign push = req_if.valid && req_if.ready;
   assign q_if.valid = (count_ff != '0);
   assign pop = q_if.valid && q_if.ready;
   assign q_if.func = func_ff[rd_ptr_ff];
   assign q_if.data_byte = data_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         func_ff[wr_ptr_ff] <= req_if.func;
         data_ff[wr_ptr_ff] <= req_if.data_byte;
      end
   end
endmodule

/* hdl/ccmp_back.sv */
// Back end: CCM sequencer with key expansion, round-iterative AES and result register.
module ccmp_back (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data,
   ccmp_req_if.sink    q_if,
   ccmp_rsp_if.source  rsp_if
);
   ccmp_pkg::state_type state_ff, state_in;
   ccmp_pkg::phase_type phase_ff, phase_in;
   ccmp_pkg::dest_type  dest_ff, dest_in;

   logic [127:0] rk_ff [ccmp_pkg::NUM_ROUND_KEYS];
   logic [127:0] key_ff, key_in, aes_ff, aes_in, mac_ff, mac_in, buf_ff, buf_in, ks_ff, ks_in;
   logic [63:0]  mask_ff, mask_in;
   logic [3:0]   round_ff, round_in, pos_ff, pos_in;
   logic [16:0]  seen_ff, seen_in, seen_inc;
   logic [15:0]  ctr_ff, ctr_in;
   logic [7:0]   data_ff, data_in;
   logic [2:0]   tag_ff, tag_in;
   logic         ok_ff, ok_in, sec_done_ff, sec_done_in;
   logic [103:0] nonce_ff, nonce_in;
   logic [15:0]  aad_ff, aad_in, msg_ff, msg_in;
   logic         dir_ff, dir_in;

   // Configuration registers
   logic [63:0] cfg_key_hi_ff, cfg_key_lo_ff, cfg_nonce_up_ff;
   logic [39:0] cfg_nonce_lo_ff;
   logic [15:0] cfg_aad_ff, cfg_msg_ff;
   logic        cfg_dir_ff;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic       rsp_ok_ff, rsp_ok_in, rsp_last_ff, rsp_last_in;

   logic         pop, out_free, blk_end, aad_done, msg_done, rk_we;
   logic [127:0] aes_src, aes_next, key_new, mac_xor_mask;
   logic [7:0]   ks_byte, cipher_byte;

   assign q_if.ready = (state_ff == ccmp_pkg::ST_IDLE);
   assign pop = q_if.valid && q_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign seen_inc = seen_ff + 17'd1;
   assign blk_end = (pos_ff == 4'd15);
   assign aad_done = (seen_inc >= {1'b0, aad_ff});
   assign msg_done = (seen_inc >= {1'b0, msg_ff});
   assign aes_next = ccmp_pkg::aes_round(aes_ff, round_ff == 4'(ccmp_pkg::LAST_ROUND))
                     ^ rk_ff[round_ff];
   assign key_new = ccmp_pkg::key_next(key_ff, ccmp_pkg::RCON[round_ff - 4'd1]);
   assign ks_byte = ccmp_pkg::get_byte(ks_ff, pos_ff);
   assign cipher_byte = data_ff ^ ks_byte;
   assign mac_xor_mask = mac_ff ^ {mask_ff, 64'd0};

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_byte = rsp_byte_ff;
   assign rsp_if.kind = rsp_kind_ff;
   assign rsp_if.auth_ok = rsp_ok_ff;
   assign rsp_if.last = rsp_last_ff;

   // AES input block selection
   always_comb begin
      unique case (dest_ff)
         ccmp_pkg::DST_B0: aes_src = {((aad_ff != 16'd0) ? ccmp_pkg::ADATA_FLAG : 8'd0)
                                      | ccmp_pkg::B0_FLAGS, nonce_ff, msg_ff};
         ccmp_pkg::DST_MASK: aes_src = {ccmp_pkg::CTR_FLAGS, nonce_ff, 16'd0};
         ccmp_pkg::DST_KS: aes_src = {ccmp_pkg::CTR_FLAGS, nonce_ff, ctr_ff};
         ccmp_pkg::DST_ABSORB: aes_src = mac_ff ^ buf_ff;
         default: aes_src = mac_ff ^ buf_ff;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccmp_pkg::ST_IDLE: begin
            if (pop) begin
               if (q_if.func == ccmp_pkg::FUNC_START) begin
                  state_in = ccmp_pkg::ST_KEY;
               end else begin
                  unique case (phase_ff)
                     ccmp_pkg::PH_AAD: begin
                        if (blk_end || aad_done) state_in = ccmp_pkg::ST_LOAD;
                     end
                     ccmp_pkg::PH_MSG: begin
                        state_in = (pos_ff == 4'd0) ? ccmp_pkg::ST_LOAD : ccmp_pkg::ST_MSG;
                     end
                     ccmp_pkg::PH_MIC: begin
                        if (seen_ff[2:0] == 3'd7) state_in = ccmp_pkg::ST_VERIFY;
                     end
                     default: state_in = ccmp_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         ccmp_pkg::ST_KEY: begin
            if (round_ff == 4'(ccmp_pkg::LAST_ROUND)) state_in = ccmp_pkg::ST_LOAD;
         end
         ccmp_pkg::ST_LOAD: state_in = ccmp_pkg::ST_RUN;
         ccmp_pkg::ST_RUN: begin
            if (round_ff == 4'(ccmp_pkg::LAST_ROUND)) begin
               unique case (dest_ff)
                  ccmp_pkg::DST_B0: state_in = ccmp_pkg::ST_LOAD;
                  ccmp_pkg::DST_MASK: state_in = (aad_ff != 16'd0) ? ccmp_pkg::ST_IDLE
                                                                   : ccmp_pkg::ST_SECTION;
                  ccmp_pkg::DST_KS: state_in = ccmp_pkg::ST_MSG;
                  default: state_in = sec_done_ff ? ccmp_pkg::ST_SECTION : ccmp_pkg::ST_IDLE;
               endcase
            end
         end
         ccmp_pkg::ST_SECTION: begin
            if ((phase_ff == ccmp_pkg::PH_AAD && msg_ff != 16'd0) || dir_ff) begin
               state_in = ccmp_pkg::ST_IDLE;
            end else begin
               state_in = ccmp_pkg::ST_TAG;
            end
         end
         ccmp_pkg::ST_MSG: begin
            if (out_free) begin
               state_in = (blk_end || msg_done) ? ccmp_pkg::ST_LOAD : ccmp_pkg::ST_IDLE;
            end
         end
         ccmp_pkg::ST_TAG: begin
            if (out_free && tag_ff == 3'd7) state_in = ccmp_pkg::ST_IDLE;
         end
         ccmp_pkg::ST_VERIFY: begin
            if (out_free) state_in = ccmp_pkg::ST_IDLE;
         end
         default: state_in = ccmp_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result outputs
   always_comb begin
      phase_in = phase_ff;
      dest_in = dest_ff;
      key_in = key_ff;
      aes_in = aes_ff;
      mac_in = mac_ff;
      buf_in = buf_ff;
      ks_in = ks_ff;
      mask_in = mask_ff;
      round_in = round_ff;
      pos_in = pos_ff;
      seen_in = seen_ff;
      ctr_in = ctr_ff;
      data_in = data_ff;
      tag_in = tag_ff;
      ok_in = ok_ff;
      sec_done_in = sec_done_ff;
      nonce_in = nonce_ff;
      aad_in = aad_ff;
      msg_in = msg_ff;
      dir_in = dir_ff;
      rk_we = 1'b0;
      rsp_valid_in = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_ok_in = rsp_ok_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ccmp_pkg::ST_IDLE: begin
            if (pop) begin
               if (q_if.func == ccmp_pkg::FUNC_START) begin
                  // Latch packet setup and begin key expansion
                  nonce_in = {cfg_nonce_up_ff, cfg_nonce_lo_ff};
                  aad_in = cfg_aad_ff;
                  msg_in = cfg_msg_ff;
                  dir_in = cfg_dir_ff;
                  key_in = {cfg_key_hi_ff, cfg_key_lo_ff};
                  rk_we = 1'b1;
                  round_in = 4'd1;
                  phase_in = ccmp_pkg::PH_IDLE;
               end else begin
                  unique case (phase_ff)
                     ccmp_pkg::PH_AAD: begin
                        buf_in = ccmp_pkg::set_byte(buf_ff, pos_ff, q_if.data_byte);
                        pos_in = pos_ff + 4'd1;
                        seen_in = seen_inc;
                        dest_in = ccmp_pkg::DST_ABSORB;
                        sec_done_in = aad_done;
                        round_in = 4'd0;
                     end
                     ccmp_pkg::PH_MSG: begin
                        data_in = q_if.data_byte;
                        dest_in = ccmp_pkg::DST_KS;
                        round_in = 4'd0;
                     end
                     ccmp_pkg::PH_MIC: begin
                        ok_in = ok_ff && (ccmp_pkg::get_byte(mac_xor_mask, {1'b0, seen_ff[2:0]})
                                          == q_if.data_byte);
                        seen_in = seen_inc;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ccmp_pkg::ST_KEY: begin
            key_in = key_new;
            rk_we = 1'b1;
            if (round_ff == 4'(ccmp_pkg::LAST_ROUND)) begin
               round_in = 4'd0;
               dest_in = ccmp_pkg::DST_B0;
            end else begin
               round_in = round_ff + 4'd1;
            end
         end
         ccmp_pkg::ST_LOAD: begin
            aes_in = aes_src ^ rk_ff[round_ff];
            round_in = 4'd1;
            if (dest_ff == ccmp_pkg::DST_KS) ctr_in = ctr_ff + 16'd1;
         end
         ccmp_pkg::ST_RUN: begin
            aes_in = aes_next;
            round_in = round_ff + 4'd1;
            if (round_ff == 4'(ccmp_pkg::LAST_ROUND)) begin
               round_in = 4'd0;
               unique case (dest_ff)
                  ccmp_pkg::DST_B0: begin
                     mac_in = aes_next;
                     dest_in = ccmp_pkg::DST_MASK;
                  end
                  ccmp_pkg::DST_MASK: begin
                     mask_in = aes_next[127:64];
                     ks_in = '0;
                     ctr_in = 16'd1;
                     seen_in = '0;
                     phase_in = ccmp_pkg::PH_AAD;
                     if (aad_ff != 16'd0) begin
                        buf_in = {aad_ff, 112'd0};
                        pos_in = 4'd2;
                     end else begin
                        buf_in = '0;
                        pos_in = 4'd0;
                     end
                  end
                  ccmp_pkg::DST_KS: ks_in = aes_next;
                  default: begin
                     mac_in = aes_next;
                     buf_in = '0;
                     pos_in = 4'd0;
                  end
               endcase
            end
         end
         ccmp_pkg::ST_SECTION: begin
            seen_in = '0;
            pos_in = 4'd0;
            tag_in = 3'd0;
            if (phase_ff == ccmp_pkg::PH_AAD && msg_ff != 16'd0) begin
               phase_in = ccmp_pkg::PH_MSG;
            end else if (dir_ff) begin
               phase_in = ccmp_pkg::PH_MIC;
               ok_in = 1'b1;
            end
         end
         ccmp_pkg::ST_MSG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in = cipher_byte;
               rsp_kind_in = ccmp_pkg::KIND_MSG;
               rsp_ok_in = 1'b0;
               rsp_last_in = 1'b0;
               buf_in = ccmp_pkg::set_byte(buf_ff, pos_ff, dir_ff ? cipher_byte : data_ff);
               pos_in = pos_ff + 4'd1;
               seen_in = seen_inc;
               dest_in = ccmp_pkg::DST_ABSORB;
               sec_done_in = msg_done;
               round_in = 4'd0;
            end
         end
         ccmp_pkg::ST_TAG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in = ccmp_pkg::get_byte(mac_xor_mask, {1'b0, tag_ff});
               rsp_kind_in = ccmp_pkg::KIND_MIC;
               rsp_ok_in = 1'b0;
               rsp_last_in = (tag_ff == 3'd7);
               tag_in = tag_ff + 3'd1;
               if (tag_ff == 3'd7) phase_in = ccmp_pkg::PH_IDLE;
            end
         end
         ccmp_pkg::ST_VERIFY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in = 8'd0;
               rsp_kind_in = ccmp_pkg::KIND_VERIFY;
               rsp_ok_in = ok_ff;
               rsp_last_in = 1'b1;
               phase_in = ccmp_pkg::PH_IDLE;
               seen_in = '0;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccmp_pkg::ST_IDLE;
         phase_ff <= ccmp_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_key_hi_ff <= '0;
         cfg_key_lo_ff <= '0;
         cfg_nonce_up_ff <= '0;
         cfg_nonce_lo_ff <= '0;
         cfg_aad_ff <= '0;
         cfg_msg_ff <= '0;
         cfg_dir_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               ccmp_pkg::CSR_KEY_HIGH: cfg_key_hi_ff <= csr_wr_data;
               ccmp_pkg::CSR_KEY_LOW: cfg_key_lo_ff <= csr_wr_data;
               ccmp_pkg::CSR_NONCE_UPPER: cfg_nonce_up_ff <= csr_wr_data;
               ccmp_pkg::CSR_NONCE_LOWER: cfg_nonce_lo_ff <= csr_wr_data[39:0];
               ccmp_pkg::CSR_AAD_LENGTH: cfg_aad_ff <= csr_wr_data[15:0];
               ccmp_pkg::CSR_MESSAGE_LENGTH: cfg_msg_ff <= csr_wr_data[15:0];
               ccmp_pkg::CSR_DIRECTION: cfg_dir_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dest_ff <= dest_in;
      key_ff <= key_in;
      aes_ff <= aes_in;
      mac_ff <= mac_in;
      buf_ff <= buf_in;
      ks_ff <= ks_in;
      mask_ff <= mask_in;
      round_ff <= round_in;
      pos_ff <= pos_in;
      seen_ff <= seen_in;
      ctr_ff <= ctr_in;
      data_ff <= data_in;
      tag_ff <= tag_in;
      ok_ff <= ok_in;
      sec_done_ff <= sec_done_in;
      nonce_ff <= nonce_in;
      aad_ff <= aad_in;
      msg_ff <= msg_in;
      dir_ff <= dir_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
      if (rk_we) begin
         rk_ff[(state_ff == ccmp_pkg::ST_KEY) ? round_ff : 4'd0] <= key_in;
      end
   end
endmodule

/* hdl/aes128_ccm_ccmp_engine.sv */
// Top level: AES-128 CCM (CCMP) engine, byte-streamed, front queue plus back sequencer.
// A start request runs key expansion, then two AES blocks (B0 and the counter-0 tag mask),
//   then the MIC bytes of an empty encrypt packet.
// Each 16-byte block takes an AES pass for the CBC-MAC, and a message block one more for the
//   CTR keystream; bytes wait in the queue while the single round-iterative AES unit is busy.
// Reset: synchronous, active high; clears the queue, the sequencer, the packet phase,
//   the result register and the configuration registers.
module aes128_ccm_ccmp_engine #(
   parameter int QUEUE_DEPTH = ccmp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data,
   ccmp_req_if.sink    req_if,
   ccmp_rsp_if.source  rsp_if
);
   ccmp_req_if q_if ();

   ccmp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_if   (q_if)
   );

   ccmp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_if        (q_if),
      .rsp_if      (rsp_if)
   );
endmodule

/* hdl/ccmp_checker.sv */
// Checker: port-level assertions on the response channel, bound to the top level.
module ccmp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_kind,
   input logic       rsp_auth_ok,
   input logic       rsp_last
);
   // A stalled response stays valid and keeps its byte and kind
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_kind))
      else $error("response changed while stalled");

   // A verify result carries a zero byte and closes the packet
   a_verify_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ccmp_pkg::KIND_VERIFY |-> rsp_out_byte == 8'd0 && rsp_last)
      else $error("malformed verify result");

   // Match flag only on verify results
   a_ok_only_verify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ccmp_pkg::KIND_VERIFY |-> !rsp_auth_ok)
      else $error("auth flag on a data result");

   // Message bytes never close a packet
   a_msg_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ccmp_pkg::KIND_MSG |-> !rsp_last)
      else $error("last flag on a message byte");

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind aes128_ccm_ccmp_engine ccmp_checker u_ccmp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_out_byte (rsp_if.out_byte),
   .rsp_kind     (rsp_if.kind),
   .rsp_auth_ok  (rsp_if.auth_ok),
   .rsp_last     (rsp_if.last)
);

/* tb/tb_aes128_ccm_ccmp_engine.sv */
// Testbench: CCM packets against a byte-level CCM predictor, random stalls.
module tb_aes128_ccm_ccmp_engine;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] block_type [16];

   // Expected CCM results, predicted per accepted request
   class ccm_scoreboard;
      typedef struct {
         logic [7:0] out_byte;
         logic [1:0] kind;
         logic       auth_ok;
         logic       last;
      } ccm_result_type;

      ccm_result_type expected_results[$];
      logic [63:0] csr_shadow [7];
      logic [7:0]  round_key [11][16];
      block_type   mac_state, mac_block, keystream;
      logic [7:0]  tag_mask [8];
      logic [7:0]  nonce [13];
      ccmp_pkg::phase_type phase;
      int          blk_pos, byte_count, ctr_value;
      int          pkt_aad, pkt_msg, pkt_dir;
      int          mismatches;

      function new();
         foreach (csr_shadow[i]) csr_shadow[i] = '0;
         for (int i = 0; i < 16; i++) begin
            mac_state[i] = '0;
            mac_block[i] = '0;
            keystream[i] = '0;
         end
         phase = ccmp_pkg::PH_IDLE;
         mismatches = 0;
      endfunction

      function logic [7:0] gf_double(input logic [7:0] v);
         return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
      endfunction

      function void expand_key();
         logic [7:0] w [176];
         logic [7:0] t [4];
         logic [7:0] t0;
         for (int i = 0; i < 8; i++) begin
            w[i] = csr_shadow[ccmp_pkg::CSR_KEY_HIGH][63 - 8*i -: 8];
            w[8 + i] = csr_shadow[ccmp_pkg::CSR_KEY_LOW][63 - 8*i -: 8];
         end
         for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) t[j] = w[4*(i-1) + j];
            if (i % 4 == 0) begin
               t0 = t[0];
               t[0] = ccmp_pkg::SBOX[t[1]] ^ ccmp_pkg::RCON[i/4 - 1];
               t[1] = ccmp_pkg::SBOX[t[2]];
               t[2] = ccmp_pkg::SBOX[t[3]];
               t[3] = ccmp_pkg::SBOX[t0];
            end
            for (int j = 0; j < 4; j++) w[4*i + j] = w[4*(i-4) + j] ^ t[j];
         end
         for (int r = 0; r < 11; r++)
            for (int k = 0; k < 16; k++) round_key[r][k] = w[16*r + k];
      endfunction

      function void cipher(input block_type din, output block_type dout);
         block_type s, t;
         logic [7:0] a0, a1, a2, a3, mix;
         for (int i = 0; i < 16; i++) s[i] = din[i] ^ round_key[0][i];
         for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
               for (int i = 0; i < 4; i++)
                  t[i + 4*c] = ccmp_pkg::SBOX[s[i + 4*((c + i) % 4)]];
            if (r < 10) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                  mix = a0 ^ a1 ^ a2 ^ a3;
                  t[4*c]   = a0 ^ mix ^ gf_double(a0 ^ a1);
                  t[4*c+1] = a1 ^ mix ^ gf_double(a1 ^ a2);
                  t[4*c+2] = a2 ^ mix ^ gf_double(a2 ^ a3);
                  t[4*c+3] = a3 ^ mix ^ gf_double(a3 ^ a0);
               end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key[r][i];
         end
         dout = s;
      endfunction

      function void ctr_block(input int ctr, output block_type dout);
         block_type a;
         a[0] = ccmp_pkg::CTR_FLAGS;
         for (int i = 0; i < 13; i++) a[1 + i] = nonce[i];
         a[14] = ctr[15:8];
         a[15] = ctr[7:0];
         cipher(a, dout);
      endfunction

      // CBC-MAC step over the gathered block
      function void absorb();
         block_type x;
         for (int i = 0; i < 16; i++) x[i] = mac_state[i] ^ mac_block[i];
         cipher(x, mac_state);
         for (int i = 0; i < 16; i++) mac_block[i] = '0;
         blk_pos = 0;
      endfunction

      function void push(input logic [7:0] b, input logic [1:0] k, input logic ok,
                         input logic lst);
         ccm_result_type r;
         r.out_byte = b; r.kind = k; r.auth_ok = ok; r.last = lst;
         expected_results.push_back(r);
      endfunction

      function logic [7:0] tag_byte(input int i);
         return mac_state[i] ^ tag_mask[i];
      endfunction

      function void end_section();
         if (phase == ccmp_pkg::PH_AAD && pkt_msg > 0) begin
            phase = ccmp_pkg::PH_MSG;
            byte_count = 0;
            blk_pos = 0;
            return;
         end
         byte_count = 0;
         blk_pos = 0;
         if (pkt_dir != 0) begin
            phase = ccmp_pkg::PH_MIC;
            return;
         end
         for (int i = 0; i < 8; i++) push(tag_byte(i), ccmp_pkg::KIND_MIC, 1'b0, i == 7);
         phase = ccmp_pkg::PH_IDLE;
      endfunction

      function void start_packet();
         block_type b0, s0;
         for (int i = 0; i < 8; i++)
            nonce[i] = csr_shadow[ccmp_pkg::CSR_NONCE_UPPER][63 - 8*i -: 8];
         for (int i = 0; i < 5; i++)
            nonce[8 + i] = csr_shadow[ccmp_pkg::CSR_NONCE_LOWER][39 - 8*i -: 8];
         pkt_aad = csr_shadow[ccmp_pkg::CSR_AAD_LENGTH][15:0];
         pkt_msg = csr_shadow[ccmp_pkg::CSR_MESSAGE_LENGTH][15:0];
         pkt_dir = csr_shadow[ccmp_pkg::CSR_DIRECTION][0];
         expand_key();
         b0[0] = (pkt_aad > 0 ? ccmp_pkg::ADATA_FLAG : 8'h00) | ccmp_pkg::B0_FLAGS;
         for (int i = 0; i < 13; i++) b0[1 + i] = nonce[i];
         b0[14] = pkt_msg[15:8];
         b0[15] = pkt_msg[7:0];
         cipher(b0, mac_state);
         ctr_block(0, s0);
         for (int i = 0; i < 8; i++) tag_mask[i] = s0[i];
         for (int i = 0; i < 16; i++) begin
            mac_block[i] = '0;
            keystream[i] = '0;
         end
         ctr_value = 1;
         byte_count = 0;
         blk_pos = 0;
         phase = ccmp_pkg::PH_AAD;
         if (pkt_aad > 0) begin
            // two-byte big-endian length prefix, even for the largest lengths
            mac_block[0] = pkt_aad[15:8];
            mac_block[1] = pkt_aad[7:0];
            blk_pos = 2;
         end else begin
            end_section();
         end
      endfunction

      // Accepted request: advance the prediction
      function void note_request(input logic func, input logic [7:0] b);
         logic [7:0] c;
         bit ok;
         if (func == ccmp_pkg::FUNC_START) begin
            start_packet();
            return;
         end
         case (phase)
            ccmp_pkg::PH_AAD: begin
               mac_block[blk_pos] = b;
               blk_pos++;
               byte_count++;
               if (blk_pos >= 16 || byte_count >= pkt_aad) absorb();
               if (byte_count >= pkt_aad) end_section();
            end
            ccmp_pkg::PH_MSG: begin
               if (blk_pos == 0) begin
                  ctr_block(ctr_value, keystream);
                  ctr_value = (ctr_value + 1) & 16'hffff;
               end
               c = b ^ keystream[blk_pos];
               mac_block[blk_pos] = pkt_dir != 0 ? c : b;
               blk_pos++;
               byte_count++;
               push(c, ccmp_pkg::KIND_MSG, 1'b0, 1'b0);
               if (blk_pos >= 16 || byte_count >= pkt_msg) absorb();
               if (byte_count >= pkt_msg) end_section();
            end
            ccmp_pkg::PH_MIC: begin
               tag_mask[byte_count] = tag_mask[byte_count] ^ b;
               byte_count++;
               if (byte_count >= 8) begin
                  // mask now holds received ^ S0; match means it equals the MAC
                  ok = 1;
                  for (int i = 0; i < 8; i++) if (tag_mask[i] != mac_state[i]) ok = 0;
                  push(8'h00, ccmp_pkg::KIND_VERIFY, ok, 1'b1);
                  phase = ccmp_pkg::PH_IDLE;
                  byte_count = 0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(input logic [7:0] b, input logic [1:0] k, input logic ok,
                                 input logic lst);
         ccm_result_type e;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: byte %h kind %0d ok %b last %b", b, k, ok, lst);
            return;
         end
         e = expected_results.pop_front();
         if (e.out_byte !== b || e.kind !== k || e.auth_ok !== ok || e.last !== lst) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected %h %0d %b %b, got %h %0d %b %b",
                        e.out_byte, e.kind, e.auth_ok, e.last, b, k, ok, lst);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 80;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wr_data;
   ccmp_req_if req ();
   ccmp_rsp_if rsp ();

   aes128_ccm_ccmp_engine uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_if(req), .rsp_if(rsp)
   );

   ccm_scoreboard sb = new();
   bit gaps_on = 1;
   int requests_sent = 0;
   int cycle_count = 0;
   int stall_left = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("aes128_ccm_ccmp_engine test failed");
         $finish;
      end
   end

   // Response side: random stall bursts, check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result(rsp.out_byte, rsp.kind, rsp.auth_ok, rsp.last);
      if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic send_request(input logic func, input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= func;
      req.data_byte <= b;
      do @(posedge clock); while (!req.ready);
      sb.note_request(func, b);
      requests_sent++;
   endtask

   // Wait until every response is in and the engine has settled
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [63:0] nu, input logic [39:0] nl,
                            input logic [15:0] aad, input logic [15:0] msg, input logic dir);
      logic [63:0] vals [7];
      vals = '{kh, kl, nu, {24'h0, nl}, {48'h0, aad}, {48'h0, msg}, {63'h0, dir}};
      drain();
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wr_data <= vals[i];
         sb.csr_shadow[i] = vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // One packet; stops early after cut_after data bytes (negative: full packet)
   task automatic run_packet(input int aad, input int msg, input bit dir,
                             input int cut_after, input bit good_tag, input int surplus);
      int total, sent, bad_pos;
      total = aad + msg + (dir ? 8 : 0);
      sent = 0;
      bad_pos = $urandom_range(0, 7);
      send_request(ccmp_pkg::FUNC_START, 8'($urandom));
      for (int i = 0; i < total; i++) begin
         if (cut_after >= 0 && sent >= cut_after) return;
         if (i >= aad + msg)
            send_request(ccmp_pkg::FUNC_DATA, sb.tag_byte(i - aad - msg) ^
                         ((!good_tag && (i - aad - msg) == bad_pos) ?
                          8'($urandom_range(1, 255)) : 8'h00));
         else
            send_request(ccmp_pkg::FUNC_DATA, 8'($urandom));
         sent++;
      end
      for (int i = 0; i < surplus; i++) send_request(ccmp_pkg::FUNC_DATA, 8'($urandom));
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int aad, msg;
      bit dir;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req.valid = 1'b0;
      req.func = ccmp_pkg::FUNC_START;
      req.data_byte = '0;
      rsp.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // data while idle is ignored
      send_request(ccmp_pkg::FUNC_DATA, 8'hff);
      send_request(ccmp_pkg::FUNC_DATA, 8'h00);
      // empty encrypt packet, all-zero and all-one settings
      configure('0, '0, '0, '0, 16'd0, 16'd0, 1'b0);
      run_packet(0, 0, 0, -1, 1, 0);
      configure('1, '1, '1, '1, 16'd0, 16'd0, 1'b0);
      run_packet(0, 0, 0, -1, 1, 1);
      // empty decrypt packet goes straight to the tag
      configure(rand64(), rand64(), rand64(), 40'($urandom), 16'd0, 16'd0, 1'b1);
      run_packet(0, 0, 1, -1, 1, 0);
      // prefix plus AAD fills one block exactly
      configure(rand64(), rand64(), rand64(), 40'($urandom), 16'd14, 16'd16, 1'b0);
      run_packet(14, 16, 0, -1, 1, 0);
      // largest lengths, abandoned by a restart
      configure(rand64(), rand64(), rand64(), 40'hff_ffff_ffff, 16'hffff, 16'hffff, 1'b1);
      run_packet(65535, 65535, 1, 3, 1, 0);
      configure(rand64(), rand64(), rand64(), 40'($urandom), 16'hff00, 16'd1, 1'b0);
      run_packet(65280, 1, 0, 2, 1, 0);
      // start during a packet, then a full decrypt with a wrong tag
      configure(rand64(), rand64(), rand64(), 40'($urandom), 16'd1, 16'd1, 1'b1);
      run_packet(1, 1, 1, 1, 1, 0);
      run_packet(1, 1, 1, -1, 0, 0);

      // random packets, mostly well formed
      while (requests_sent < 210) begin
         if (requests_sent > 170) gaps_on = 0;
         aad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 18);
         msg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 18);
         dir = $urandom_range(0, 1);
         configure(rand64(), rand64(), rand64(), 40'({$urandom, $urandom}),
                   16'(aad), 16'(msg), dir);
         run_packet(aad, msg, dir,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, aad + msg) : -1,
                    $urandom_range(0, 3) != 0, $urandom_range(0, 2));
      end

      drain();
      if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
         $display("aes128_ccm_ccmp_engine test passed");
      end else begin
         $display("aes128_ccm_ccmp_engine test failed");
      end
      $finish;
   end
endmodule

/* files.f */
hdl/ccmp_pkg.sv
hdl/ccmp_if.sv
hdl/ccmp_front.sv
hdl/ccmp_back.sv
hdl/aes128_ccm_ccmp_engine.sv
hdl/ccmp_checker.sv
tb/tb_aes128_ccm_ccmp_engine.sv
